// File: hw/rtl/gkwg_pkg.sv
`default_nettype none
package gkwg_pkg;

   // Sizing defaults and fixed limits
   localparam int KERNEL_DEPTH_DEF = 1024;
   localparam int MAX_WINDOW_SIDE  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int GRID_W     = 11;
   localparam int CW_W       = 10;
   localparam int NPTS_W     = 11;

   // Request and response field widths
   localparam int COORD_W  = 16;
   localparam int TIDX_W   = 10;
   localparam int TVAL_W   = 16;
   localparam int BOUND_W  = 10;
   localparam int SLOT_W   = 6;
   localparam int WEIGHT_W = 16;

   // Arithmetic unit widths
   localparam int RADICAND_W = 52;
   localparam int ROOT_W     = 26;
   localparam int NM1_W      = 12;
   localparam int DIVIDEND_W = ROOT_W + NM1_W;
   localparam int DIVISOR_W  = CW_W;
   localparam int QUOT_W     = DIVIDEND_W - DIVISOR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_SIZE     = 2'd0,
      CSR_CONV_WIDTH    = 2'd1,
      CSR_KERNEL_POINTS = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_GRID = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                 opcode;
      logic signed [COORD_W-1:0]  kx;
      logic signed [COORD_W-1:0]  ky;
      logic [TIDX_W-1:0]          table_index;
      logic [TVAL_W-1:0]          table_value;
   } req_type;

   typedef struct packed {
      logic [BOUND_W-1:0]  x_low;
      logic [BOUND_W-1:0]  x_high;
      logic [BOUND_W-1:0]  y_low;
      logic [BOUND_W-1:0]  y_high;
      logic [SLOT_W-1:0]   slot;
      logic [WEIGHT_W-1:0] weight;
      logic                window_empty;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
      logic               empty;
   } axis_type;

endpackage
`default_nettype wire

// File: hw/rtl/gkwg_table.sv
`default_nettype none
module gkwg_table #(
   parameter int DEPTH = gkwg_pkg::KERNEL_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [gkwg_pkg::TVAL_W-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr0,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr1,
   output logic [gkwg_pkg::TVAL_W-1:0]     rd_data0,
   output logic [gkwg_pkg::TVAL_W-1:0]     rd_data1
);
   import gkwg_pkg::*;

   logic [TVAL_W-1:0] mem [DEPTH];
   logic [TVAL_W-1:0] rd0_ff;
   logic [TVAL_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gkwg_sqrt.sv
`default_nettype none
module gkwg_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gkwg_pkg::RADICAND_W-1:0]    radicand,
   output logic                               done,
   output logic [gkwg_pkg::ROOT_W-1:0]        root
);
   import gkwg_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 2;

   logic [RADICAND_W-1:0] val_ff, val_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [REM_W+1:0]      rem_sh;
   logic [REM_W+1:0]      trial;

   // One result bit per cycle, most significant first.
   always_comb begin
      rem_sh  = {rem_ff, val_ff[RADICAND_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = val_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gkwg_div.sv
`default_nettype none
module gkwg_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gkwg_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [gkwg_pkg::DIVISOR_W-1:0]     divisor,
   output logic                               done,
   output logic [gkwg_pkg::QUOT_W-1:0]        quotient
);
   import gkwg_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   // The quotient is known to fit QUOT_W bits, so the top DIVISOR_W bits of
   // the dividend already form a partial remainder below the divisor.
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [QUOT_W-1:0]    low_ff, low_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, low_ff[QUOT_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[DIVIDEND_W-1 -: DIVISOR_W];
         low_in  = dividend[QUOT_W-1:0];
         dvs_in  = divisor;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : DIVISOR_W'(trial);
         low_in = {low_ff[QUOT_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gridding_kernel_weight_gen.sv
`default_nettype none
// Gridding kernel weight generator. A load request (opcode OP_LOAD) writes one
// entry of the kernel table; an index at or beyond KERNEL_DEPTH is dropped. A
// grid request (OP_GRID) takes one k-space sample, works out its clipped
// window of grid points (at most MAX_WINDOW_SIDE per axis) and returns one
// response per window point, columns outer and rows inner, each carrying the
// window bounds, its slot and a Q1.15 weight; an empty window returns a single
// response flagged window_empty. The block works on one request at a time and
// holds req_stall high meanwhile. A grid request first works out the window,
// then for each point forms the distance squares; a point inside the kernel
// radius then passes through the bit-serial square root, the bit-serial
// divider that scales the radius into a table position, the two table reads
// and the interpolation. The response sits in an output register, so
// computation of the next point continues while a response waits under
// rsp_stall. The kernel table is a memory with one write and two read ports
// and is not cleared at reset: a grid request must only touch entries that
// have been loaded. Configuration writes on the csr_ port are taken at any
// time but must only be made while the block is idle.
module gridding_kernel_weight_gen #(
   parameter int KERNEL_DEPTH = gkwg_pkg::KERNEL_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gkwg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gkwg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [gkwg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gkwg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gkwg_pkg::*;

   localparam int AW = $clog2(KERNEL_DEPTH);

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_KMUL   = 15'b000000000000010,
      ST_BOUNDS = 15'b000000000000100,
      ST_POINT  = 15'b000000000001000,
      ST_SQX    = 15'b000000000010000,
      ST_SQY    = 15'b000000000100000,
      ST_CMP    = 15'b000000001000000,
      ST_ROOT   = 15'b000000010000000,
      ST_SCALE  = 15'b000000100000000,
      ST_DIVIDE = 15'b000001000000000,
      ST_INDEX  = 15'b000010000000000,
      ST_FETCH  = 15'b000100000000000,
      ST_WLO    = 15'b001000000000000,
      ST_WHI    = 15'b010000000000000,
      ST_EMIT   = 15'b100000000000000
   } state_type;

   // Truncation toward zero of a Q15 quantity to an integer.
   function automatic logic signed [13:0] trunc_q15(input logic signed [28:0] n);
      logic [28:0]        mag;
      logic signed [13:0] q;
      mag = n[28] ? 29'(-n) : 29'(n);
      q   = 14'(mag >> 15);
      return n[28] ? -q : q;
   endfunction

   // Clipped window bounds of one axis, plus the bound fields as reported
   // (saturated into the grid, which only matters for an empty window).
   function automatic axis_type axis_calc(input logic signed [27:0] kg,
                                          input logic [GRID_W-1:0] g,
                                          input logic [CW_W-1:0] cw);
      logic signed [28:0] base;
      logic signed [28:0] reach;
      logic signed [13:0] lo;
      logic signed [13:0] hi;
      logic signed [13:0] gs;
      axis_type           r;
      base  = 29'(kg) + $signed({4'b0, g[GRID_W-1:1], 15'b0});
      reach = $signed({12'b0, cw, 7'b0});
      gs    = $signed({3'b0, g});
      lo    = trunc_q15(base - reach);
      hi    = trunc_q15(base + reach) + 14'sd1;
      if (lo < 14'sd0) begin
         lo = 14'sd0;
      end
      if (hi >= gs) begin
         hi = gs - 14'sd1;
      end
      if (hi - lo >= 14'(MAX_WINDOW_SIDE)) begin
         hi = lo + 14'(MAX_WINDOW_SIDE - 1);
      end
      r.empty = lo > hi;
      r.lo    = (lo > gs - 14'sd1) ? BOUND_W'(gs - 14'sd1) : BOUND_W'(lo);
      r.hi    = (hi < 14'sd0) ? '0 : BOUND_W'(hi);
      return r;
   endfunction

   // Configuration registers and their sanitised values.
   logic [GRID_W-1:0] grid_ff, grid_in;
   logic [CW_W-1:0]   cw_ff, cw_in;
   logic [NPTS_W-1:0] npts_ff, npts_in;
   logic [GRID_W-1:0] g_eff;
   logic [CW_W-1:0]   cw_eff;
   logic [NM1_W-1:0]  nm1;
   logic [19:0]       cwsq;
   logic [33:0]       lim_ff, lim_in;

   state_type                 state_ff, state_in;
   logic signed [COORD_W-1:0] kx_ff, kx_in, ky_ff, ky_in;
   logic signed [27:0]        kxg_ff, kxg_in, kyg_ff, kyg_in;
   axis_type                  xa, ya;
   logic [BOUND_W-1:0]        xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [BOUND_W-1:0]        ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic                      empty_ff, empty_in;
   logic [BOUND_W-1:0]        x_ff, x_in, y_ff, y_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic signed [28:0]        dx, dy;
   logic [28:0]               adx, ady;
   logic [16:0]               ax_ff, ax_in, ay_ff, ay_in;
   logic                      near_ff, near_in;
   logic [16:0]               sq_op;
   logic [33:0]               sq;
   logic [33:0]               sx_ff, sx_in, sy_ff, sy_in;
   logic [34:0]               dist2;
   logic                      in_radius;
   logic [DIVIDEND_W-1:0]     d_ff, d_in;
   logic                      div_go_ff, div_go_in;
   logic [NM1_W-1:0]          raw_idx;
   logic [NM1_W-1:0]          idx_ff, idx_in;
   logic [NM1_W-1:0]          idx_next;
   logic [15:0]               fr_ff, fr_in;
   logic [32:0]               p0_ff, p0_in;
   logic [31:0]               p1_ff, p1_in;
   logic [33:0]               wsum;
   logic [WEIGHT_W-1:0]       w_ff, w_in;
   logic                      last_pt;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_load;

   logic                      req_take;
   logic                      tbl_we;
   logic [TVAL_W-1:0]         t0, t1;
   logic                      sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]         sqrt_root;
   logic                      div_done;
   logic [QUOT_W-1:0]         div_quot;

   // ---------------------------------------------------------------------
   // Configuration. Out-of-range values are pulled into range on use.
   // ---------------------------------------------------------------------
   always_comb begin
      grid_in = grid_ff;
      cw_in   = cw_ff;
      npts_in = npts_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_SIZE:     grid_in = GRID_W'(csr_wdata);
            CSR_CONV_WIDTH:    cw_in   = CW_W'(csr_wdata);
            CSR_KERNEL_POINTS: npts_in = NPTS_W'(csr_wdata);
            default:           grid_in = grid_ff;
         endcase
      end
   end

   always_comb begin
      if (grid_ff < GRID_W'(8)) begin
         g_eff = GRID_W'(8);
      end else if (grid_ff > GRID_W'(1024)) begin
         g_eff = GRID_W'(1024);
      end else begin
         g_eff = grid_ff;
      end
      cw_eff = (cw_ff == '0) ? CW_W'(1) : cw_ff;
      if (npts_ff < NPTS_W'(2)) begin
         nm1 = NM1_W'(1);
      end else if (32'(npts_ff) > KERNEL_DEPTH) begin
         nm1 = NM1_W'(KERNEL_DEPTH - 1);
      end else begin
         nm1 = NM1_W'(npts_ff) - NM1_W'(1);
      end
      // Squared kernel radius in the units of the distance squares.
      cwsq   = 20'(cw_eff) * 20'(cw_eff);
      lim_in = {cwsq, 14'b0};
   end

   // ---------------------------------------------------------------------
   // Datapath helpers used by the sequencer.
   // ---------------------------------------------------------------------
   assign req_take = req_valid && !req_stall;
   assign tbl_we   = req_take && (req_data.opcode == OP_LOAD)
                     && (32'(req_data.table_index) < KERNEL_DEPTH);

   always_comb begin
      xa = axis_calc(kxg_ff, g_eff, cw_eff);
      ya = axis_calc(kyg_ff, g_eff, cw_eff);

      // Offsets of the current point from the sample, in Q15 grid units.
      dx  = $signed({4'b0, x_ff, 15'b0}) - $signed({4'b0, g_eff[GRID_W-1:1], 15'b0})
            - 29'(kxg_ff);
      dy  = $signed({4'b0, y_ff, 15'b0}) - $signed({4'b0, g_eff[GRID_W-1:1], 15'b0})
            - 29'(kyg_ff);
      adx = dx[28] ? 29'(-dx) : 29'(dx);
      ady = dy[28] ? 29'(-dy) : 29'(dy);

      // A single squarer is shared by the two axes.
      sq_op = (state_ff == ST_SQY) ? ay_ff : ax_ff;
      sq    = 34'(sq_op) * 34'(sq_op);

      dist2     = 35'(sx_ff) + 35'(sy_ff);
      in_radius = near_ff && (dist2 < 35'(lim_ff));

      raw_idx  = div_quot[QUOT_W-1:16];
      idx_next = idx_ff + NM1_W'(1);

      wsum    = 34'(p0_ff) + 34'(p1_ff) + 34'd32768;
      last_pt = empty_ff || ((x_ff == xhi_ff) && (y_ff == yhi_ff));
   end

   assign sqrt_start = (state_ff == ST_CMP) && in_radius;
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      kx_in     = kx_ff;
      ky_in     = ky_ff;
      kxg_in    = kxg_ff;
      kyg_in    = kyg_ff;
      xlo_in    = xlo_ff;
      xhi_in    = xhi_ff;
      ylo_in    = ylo_ff;
      yhi_in    = yhi_ff;
      empty_in  = empty_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      slot_in   = slot_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      near_in   = near_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      d_in      = d_ff;
      div_go_in = 1'b0;
      idx_in    = idx_ff;
      fr_in     = fr_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      w_in      = w_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_data.opcode == OP_GRID)) begin
               kx_in    = req_data.kx;
               ky_in    = req_data.ky;
               state_in = ST_KMUL;
            end
         end
         ST_KMUL: begin
            kxg_in   = 28'($signed(kx_ff) * $signed({1'b0, g_eff}));
            kyg_in   = 28'($signed(ky_ff) * $signed({1'b0, g_eff}));
            state_in = ST_BOUNDS;
         end
         ST_BOUNDS: begin
            xlo_in   = xa.lo;
            xhi_in   = xa.hi;
            ylo_in   = ya.lo;
            yhi_in   = ya.hi;
            empty_in = xa.empty || ya.empty;
            x_in     = xa.lo;
            y_in     = ya.lo;
            slot_in  = '0;
            w_in     = '0;
            state_in = (xa.empty || ya.empty) ? ST_EMIT : ST_POINT;
         end
         ST_POINT: begin
            // Either offset at or above one kernel step of 2^17 already
            // puts the point outside any possible radius.
            near_in  = (adx[28:17] == '0) && (ady[28:17] == '0);
            ax_in    = adx[16:0];
            ay_in    = ady[16:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sx_in    = sq;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sy_in    = sq;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            w_in     = '0;
            state_in = in_radius ? ST_ROOT : ST_EMIT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            d_in      = DIVIDEND_W'(sqrt_root) * DIVIDEND_W'(nm1);
            div_go_in = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            idx_in   = (raw_idx > nm1 - NM1_W'(1)) ? nm1 - NM1_W'(1) : raw_idx;
            fr_in    = div_quot[15:0];
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_WLO;
         end
         ST_WLO: begin
            p0_in    = 33'(t0) * (33'h10000 - 33'(fr_ff));
            state_in = ST_WHI;
         end
         ST_WHI: begin
            p1_in    = 32'(t1) * 32'(fr_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (last_pt) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_POINT;
                  if (y_ff == yhi_ff) begin
                     y_in = ylo_ff;
                     x_in = x_ff + 1'b1;
                  end else begin
                     y_in = y_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Leaving WHI, w_ff is cleared; the rounded interpolation sum is used in EMIT.
      if (state_ff == ST_WHI) begin
         w_in = '0;
      end
   end

   // The interpolated weight is formed from the two registered products when
   // the response is loaded in EMIT; outside points carry the zero set earlier.
   logic wsum_pending_ff;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.x_low        = xlo_ff;
         rsp_in.x_high       = xhi_ff;
         rsp_in.y_low        = ylo_ff;
         rsp_in.y_high       = yhi_ff;
         rsp_in.slot         = slot_ff;
         rsp_in.weight       = wsum_pending_ff ? wsum[31:16] : w_ff;
         rsp_in.window_empty = empty_ff;
         rsp_in.last         = last_pt;
         rsp_valid_in        = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         div_go_ff       <= 1'b0;
         wsum_pending_ff <= 1'b0;
         grid_ff         <= GRID_W'(256);
         cw_ff           <= CW_W'(384);
         npts_ff         <= NPTS_W'(1024);
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         div_go_ff       <= div_go_in;
         grid_ff         <= grid_in;
         cw_ff           <= cw_in;
         npts_ff         <= npts_in;
         if (state_ff == ST_WHI) begin
            wsum_pending_ff <= 1'b1;
         end else if (state_ff == ST_CMP || state_ff == ST_BOUNDS) begin
            wsum_pending_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      kx_ff    <= kx_in;
      ky_ff    <= ky_in;
      kxg_ff   <= kxg_in;
      kyg_ff   <= kyg_in;
      xlo_ff   <= xlo_in;
      xhi_ff   <= xhi_in;
      ylo_ff   <= ylo_in;
      yhi_ff   <= yhi_in;
      empty_ff <= empty_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      slot_ff  <= slot_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      near_ff  <= near_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      d_ff     <= d_in;
      idx_ff   <= idx_in;
      fr_ff    <= fr_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      w_ff     <= w_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Kernel table and the two iterative units.
   // ---------------------------------------------------------------------
   gkwg_table #(
      .DEPTH (KERNEL_DEPTH)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_we),
      .wr_addr  (AW'(req_data.table_index)),
      .wr_data  (req_data.table_value),
      .rd_addr0 (idx_ff[AW-1:0]),
      .rd_addr1 (idx_next[AW-1:0]),
      .rd_data0 (t0),
      .rd_data1 (t1)
   );

   gkwg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({dist2[33:0], 18'b0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   gkwg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (d_ff),
      .divisor  (cw_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_empty_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.window_empty |->
         rsp_data.last && (rsp_data.slot == '0) && (rsp_data.weight == '0))
      else $error("empty window response is not a lone zero response");

   a_sqrt_owner : assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_ROOT))
      else $error("square root finished while the sequencer was not waiting");

   a_div_owner : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished while the sequencer was not waiting");

   a_window_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.window_empty |->
         (rsp_data.x_low <= rsp_data.x_high) && (rsp_data.y_low <= rsp_data.y_high))
      else $error("non-empty window with inverted bounds");

   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && !rsp_stall |=> rsp_valid)
      else $error("response was not loaded when the output was free");

endmodule
`default_nettype wire
